>>> sv/sparse_voxel_octree_decoder_unit_macros.svh
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef SPARSE_VOXEL_OCTREE_DECODER_UNIT_MACROS_SVH
`define SPARSE_VOXEL_OCTREE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define SVOD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svod assertion failed");

// next-cycle implication
`define SVOD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svod assertion failed");

`endif

>>> sv/svod_pkg.sv
`timescale 1ns / 1ps

package svod_pkg;

	localparam int MAX_LEVELS = 10;
	localparam int MASK_W     = 8;
	localparam int DIGIT_W    = 3;
	localparam int LEVEL_W    = 4;
	localparam int CODE_W     = DIGIT_W * MAX_LEVELS;
	localparam int SHIFT_W    = $clog2(CODE_W);

	typedef logic [MASK_W-1:0]  mask_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CODE_W-1:0]  code_t;

	// leaf beat handed from walker to emitter
	typedef struct packed {
		logic  valid;
		code_t prefix;
		mask_t mask;
		logic  more;
	} leaf_t;

	function automatic digit_t lowest_bit(input mask_t m);
		digit_t r;
		r = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = DIGIT_W'(i);
			end
		end
		return r;
	endfunction

	function automatic level_t depth_in_use(input level_t d);
		level_t r;
		r = d;
		if (d == '0) begin
			r = LEVEL_W'(1);
		end else if (d > LEVEL_W'(MAX_LEVELS)) begin
			r = LEVEL_W'(MAX_LEVELS);
		end
		return r;
	endfunction

endpackage

>>> sv/svod_walker.sv
`timescale 1ns / 1ps

`include "sparse_voxel_octree_decoder_unit_macros.svh"

module svod_walker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  svod_pkg::mask_t       node_mask,
	input  logic                  start_tree,
	input  svod_pkg::level_t      tree_depth,
	output svod_pkg::leaf_t       leaf
);

	svod_pkg::mask_t  rem_q [svod_pkg::MAX_LEVELS];
	svod_pkg::digit_t dig_q [svod_pkg::MAX_LEVELS];
	svod_pkg::level_t lvl_q;
	logic             active_q;

	svod_pkg::mask_t  eff_rem [svod_pkg::MAX_LEVELS];
	svod_pkg::mask_t  rem_d   [svod_pkg::MAX_LEVELS];
	svod_pkg::digit_t dig_d   [svod_pkg::MAX_LEVELS];
	svod_pkg::level_t lvl_d;
	logic             active_d;

	svod_pkg::level_t d;
	svod_pkg::level_t eff_lvl;
	svod_pkg::level_t lvl;
	svod_pkg::level_t pl;
	svod_pkg::digit_t pop_digit;
	svod_pkg::digit_t child;
	logic             st;
	logic             act;
	logic             is_internal;
	logic             found;
	logic [svod_pkg::SHIFT_W-1:0]                             sh;
	logic [svod_pkg::DIGIT_W*(svod_pkg::MAX_LEVELS-1)-1:0]   digs;
	svod_pkg::code_t  pre_wide;

	always_comb begin
		d       = svod_pkg::depth_in_use(tree_depth);
		st      = acc & start_tree;
		act     = st | active_q;
		eff_lvl = st ? '0 : lvl_q;
		lvl     = (eff_lvl >= svod_pkg::LEVEL_W'(svod_pkg::MAX_LEVELS)) ?
			svod_pkg::LEVEL_W'(svod_pkg::MAX_LEVELS - 1) : eff_lvl;
		for (int l = 0; l < svod_pkg::MAX_LEVELS; l++) begin
			eff_rem[l] = st ? '0 : rem_q[l];
		end
		is_internal = ({1'b0, lvl} + 5'd1) < {1'b0, d};

		// deepest level above lvl with siblings left
		found = 1'b0;
		pl    = '0;
		for (int l = 0; l < svod_pkg::MAX_LEVELS; l++) begin
			if (svod_pkg::LEVEL_W'(l) < lvl && eff_rem[l] != '0) begin
				found = 1'b1;
				pl    = svod_pkg::LEVEL_W'(l);
			end
		end
		pop_digit = svod_pkg::lowest_bit(eff_rem[pl]);
		child     = svod_pkg::lowest_bit(node_mask);

		// leaf prefix: root digit highest, low digit slot left zero
		for (int i = 0; i < svod_pkg::MAX_LEVELS - 1; i++) begin
			digs[svod_pkg::DIGIT_W*(svod_pkg::MAX_LEVELS-2-i) +: svod_pkg::DIGIT_W] = dig_q[i];
		end
		sh       = svod_pkg::SHIFT_W'(svod_pkg::DIGIT_W *
			(svod_pkg::LEVEL_W'(svod_pkg::MAX_LEVELS) - d));
		pre_wide = svod_pkg::CODE_W'(digs) >> sh;

		rem_d    = rem_q;
		dig_d    = dig_q;
		lvl_d    = lvl_q;
		active_d = active_q;
		if (acc && act) begin
			rem_d    = eff_rem;
			active_d = 1'b1;
			if (is_internal && node_mask != '0) begin
				dig_d[lvl] = child;
				rem_d[lvl] = node_mask & ~(svod_pkg::MASK_W'(1) << child);
				lvl_d      = lvl + svod_pkg::LEVEL_W'(1);
			end else if (found) begin
				dig_d[pl] = pop_digit;
				rem_d[pl] = eff_rem[pl] & ~(svod_pkg::MASK_W'(1) << pop_digit);
				lvl_d     = pl + svod_pkg::LEVEL_W'(1);
			end else begin
				active_d = 1'b0;
				lvl_d    = '0;
			end
		end

		leaf.valid  = acc && act && !is_internal && node_mask != '0;
		leaf.prefix = pre_wide << svod_pkg::DIGIT_W;
		leaf.mask   = node_mask;
		leaf.more   = found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < svod_pkg::MAX_LEVELS; l++) begin
				rem_q[l] <= '0;
				dig_q[l] <= '0;
			end
			lvl_q    <= '0;
			active_q <= 1'b0;
		end else begin
			rem_q    <= rem_d;
			dig_q    <= dig_d;
			lvl_q    <= lvl_d;
			active_q <= active_d;
		end
	end

	`SVOD_ASSERT_IMP(a_lvl_range, 1'b1, lvl_q < svod_pkg::LEVEL_W'(svod_pkg::MAX_LEVELS))
	`SVOD_ASSERT_IMP(a_idle_root, !active_q, lvl_q == '0)
	`SVOD_ASSERT_NXT(a_start_live, acc && start_tree && !leaf.valid && is_internal && node_mask != '0,
		active_q)

endmodule

>>> sv/svod_emitter.sv
`timescale 1ns / 1ps

`include "sparse_voxel_octree_decoder_unit_macros.svh"

module svod_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  svod_pkg::leaf_t  leaf,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output svod_pkg::code_t  morton_code,
	output logic             last_in_run,
	output logic             tree_complete
);

	logic            valid_q;
	svod_pkg::mask_t mask_q;
	svod_pkg::code_t prefix_q;
	logic            more_q;
	svod_pkg::digit_t low;
	logic            last;

	always_comb begin
		low           = svod_pkg::lowest_bit(mask_q);
		last          = (mask_q & (mask_q - svod_pkg::MASK_W'(1))) == '0;
		free          = !valid_q || (out_ready && last);
		out_valid     = valid_q;
		morton_code   = prefix_q | svod_pkg::CODE_W'(low);
		last_in_run   = last;
		tree_complete = last && !more_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (leaf.valid) begin
			valid_q <= 1'b1;
		end else if (valid_q && out_ready && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leaf.valid) begin
			mask_q   <= leaf.mask;
			prefix_q <= leaf.prefix;
			more_q   <= leaf.more;
		end else if (valid_q && out_ready) begin
			mask_q <= mask_q & ~(svod_pkg::MASK_W'(1) << low);
		end
	end

	`SVOD_ASSERT_IMP(a_mask_live, valid_q, mask_q != '0)
	`SVOD_ASSERT_IMP(a_no_overrun, leaf.valid, free)
	`SVOD_ASSERT_NXT(a_run_ends, valid_q && out_ready && last && !leaf.valid, !valid_q)

endmodule

>>> sv/sparse_voxel_octree_decoder_unit.sv
// Preorder sparse voxel octree decoder.
// Input channel (in_valid/in_ready): one beat per node byte, node_mask plus
// start_tree, which opens a new tree and drops any walk in progress.
// Output channel (out_valid/out_ready): one beat per leaf voxel, morton_code
// with three bits per level, last_in_run on the final code of a leaf byte,
// tree_complete on the final code of the tree.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_data sets
// tree_depth; write only while the decoder is idle.
// Internal bytes and empty bytes leave no beat; the walk state is updated
// at the accepting edge.
// A leaf byte with k set bits gives k codes, the first in the cycle after
// it is accepted, then one per cycle while out_ready is high; the code
// emitter holds one run, so in_ready is low until its final code is taken,
// and the next byte can be accepted in that same cycle.
// If out_ready is low the current code holds and input stalls behind it.
// Reset clears the walk (no tree in progress) and sets tree_depth to 10.
`timescale 1ns / 1ps

module sparse_voxel_octree_decoder_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  svod_pkg::mask_t       node_mask,
	input  logic                  start_tree,
	output logic                  out_valid,
	input  logic                  out_ready,
	output svod_pkg::code_t       morton_code,
	output logic                  last_in_run,
	output logic                  tree_complete,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  svod_pkg::level_t      cfg_data
);

	svod_pkg::level_t tree_depth_q;
	svod_pkg::leaf_t  leaf;
	logic             free;
	logic             acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = free;
	assign acc       = in_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_depth_q <= svod_pkg::LEVEL_W'(svod_pkg::MAX_LEVELS);
		end else if (cfg_valid && cfg_ready) begin
			tree_depth_q <= cfg_data;
		end
	end

	svod_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.node_mask  (node_mask),
		.start_tree (start_tree),
		.tree_depth (tree_depth_q),
		.leaf       (leaf)
	);

	svod_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.leaf          (leaf),
		.free          (free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.morton_code   (morton_code),
		.last_in_run   (last_in_run),
		.tree_complete (tree_complete)
	);

endmodule
